FILE: rtl/generational_handle_pool_core_macros.svh
// ---------------------------------------------------------------------------
// generational_handle_pool_core_macros
// Assertion shorthands for the handle pool checker. They expect clk_i and
// rst_ni in scope.
// ---------------------------------------------------------------------------
`ifndef GENERATIONAL_HANDLE_POOL_CORE_MACROS_SVH
`define GENERATIONAL_HANDLE_POOL_CORE_MACROS_SVH

// Same-cycle implication, disabled during reset
`define GHP_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset
`define GHP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/ghp_pkg.sv
// ---------------------------------------------------------------------------
// ghp_pkg
// Shared widths, command codes and status codes of the handle pool.
// ---------------------------------------------------------------------------
package ghp_pkg;

  // Default sizing
  localparam int DefCapacity = 1024;
  localparam int DefGenBits  = 16;

  // Port field widths
  localparam int CmdW    = 2;
  localparam int HIdxW   = 10;
  localparam int HGenW   = 16;
  localparam int TypeW   = 16;
  localparam int PosW    = 10;
  localparam int StatusW = 3;
  localparam int CountW  = 11;

  // Commands
  localparam logic [CmdW-1:0] CMD_ALLOC  = 2'd0;
  localparam logic [CmdW-1:0] CMD_LOOKUP = 2'd1;
  localparam logic [CmdW-1:0] CMD_FREE   = 2'd2;
  localparam logic [CmdW-1:0] CMD_READ   = 2'd3;

  // Result status
  localparam logic [StatusW-1:0] ST_OK       = 3'd0;
  localparam logic [StatusW-1:0] ST_FULL     = 3'd1;
  localparam logic [StatusW-1:0] ST_RANGE    = 3'd2;
  localparam logic [StatusW-1:0] ST_DEAD     = 3'd3;
  localparam logic [StatusW-1:0] ST_STALE    = 3'd4;
  localparam logic [StatusW-1:0] ST_NOT_LIVE = 3'd5;

endpackage

FILE: rtl/ghp_ram.sv
// ---------------------------------------------------------------------------
// ghp_ram
// Single-port synchronous RAM, one access per cycle, registered read.
// ---------------------------------------------------------------------------
module ghp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    addr_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write, or read into the output register
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end else begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/generational_handle_pool_core.sv
// ---------------------------------------------------------------------------
// generational_handle_pool_core
// Generational slot map with a packed dense table. A sparse RAM maps each
// handle index to its dense position; a dense RAM holds (index, generation)
// per position. Commands: alloc, lookup, free (swap with last), read.
// ---------------------------------------------------------------------------
//
//  channel | handshake                    | payload
//  --------+------------------------------+------------------------------------
//  in      | in_valid_i / in_ready_o      | cmd, handle_index/generation/type,
//          |                              | dense_position
//  out     | out_valid_o / out_ready_i    | status, out_index/generation/type,
//          |                              | out_position, live_count
//  cfg     | cfg_we_i (no wait)           | cfg_wdata_i -> entity_type
//
//  Errors found at accept go straight to S_OUT; alloc and read fetch the
//  dense entry, lookup and free the sparse then the dense entry; a free that
//  is not last then moves the last item and parks the freed handle, each step
//  writing both one-port RAMs. After reset a clearing pass writes every entry
//  of both RAMs with in_ready_o low; configuration writes are taken throughout.
//  One item at a time; a stalled output holds the finished result and the
//  next item is taken once that result sits in the output register.
//
module generational_handle_pool_core
  import ghp_pkg::*;
#(
  parameter int CAPACITY = DefCapacity,
  parameter int GEN_BITS = DefGenBits
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // configuration
  input  logic               cfg_we_i,
  input  logic [TypeW-1:0]   cfg_wdata_i,
  // input channel
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [CmdW-1:0]    cmd_i,
  input  logic [HIdxW-1:0]   handle_index_i,
  input  logic [HGenW-1:0]   handle_generation_i,
  input  logic [TypeW-1:0]   handle_type_i,
  input  logic [PosW-1:0]    dense_position_i,
  // output channel
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [StatusW-1:0] status_o,
  output logic [HIdxW-1:0]   out_index_o,
  output logic [HGenW-1:0]   out_generation_o,
  output logic [TypeW-1:0]   out_type_o,
  output logic [PosW-1:0]    out_position_o,
  output logic [CountW-1:0]  live_count_o
);

  localparam int IDX_W = $clog2(CAPACITY);
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int DN_W  = IDX_W + GEN_BITS;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DATA,
    S_DENSE,
    S_CHECK,
    S_MOVE,
    S_SWAP,
    S_OUT
  } state_e;

  // Control and output registers
  state_e               state_q, state_d;
  logic                 clr_busy_q, clr_busy_d;
  logic [IDX_W-1:0]     clr_cnt_q, clr_cnt_d;
  logic [CNT_W-1:0]     live_q, live_d;
  logic [TypeW-1:0]     etype_q, etype_d;
  logic                 out_valid_q, out_valid_d;
  logic [StatusW-1:0]   out_status_q, out_status_d;
  logic [HIdxW-1:0]     out_index_q, out_index_d;
  logic [HGenW-1:0]     out_gen_q, out_gen_d;
  logic [TypeW-1:0]     out_type_q, out_type_d;
  logic [PosW-1:0]      out_pos_q, out_pos_d;
  logic [CountW-1:0]    out_count_q, out_count_d;

  // Payload registers of the item at work
  logic [CmdW-1:0]      cmd_q, cmd_d;
  logic [IDX_W-1:0]     hidx_q, hidx_d;
  logic [HGenW-1:0]     hgen_q, hgen_d;
  logic [TypeW-1:0]     htyp_q, htyp_d;
  logic [IDX_W-1:0]     pos_q, pos_d;
  logic [DN_W-1:0]      freed_q, freed_d;
  logic [StatusW-1:0]   res_status_q, res_status_d;
  logic [IDX_W-1:0]     res_idx_q, res_idx_d;
  logic [GEN_BITS-1:0]  res_gen_q, res_gen_d;

  // RAM ports
  logic                 sp_we, dn_we;
  logic [IDX_W-1:0]     sp_addr, dn_addr;
  logic [IDX_W-1:0]     sp_wdata, sp_rdata;
  logic [DN_W-1:0]      dn_wdata, dn_rdata;

  // Decoded dense word and helpers
  logic [IDX_W-1:0]     rd_idx;
  logic [GEN_BITS-1:0]  rd_gen;
  logic [GEN_BITS-1:0]  gen_inc;
  logic [CNT_W-1:0]     live_m1;
  logic [IDX_W-1:0]     last_pos;
  logic                 in_accept;
  logic                 match;

  assign rd_idx    = dn_rdata[DN_W-1:GEN_BITS];
  assign rd_gen    = dn_rdata[GEN_BITS-1:0];
  assign gen_inc   = rd_gen + 1'b1;
  assign live_m1   = live_q - 1'b1;
  assign last_pos  = IDX_W'(live_m1);
  assign in_ready_o = (state_q == S_IDLE) && !clr_busy_q;
  assign in_accept = in_valid_i && in_ready_o;
  assign match     = (rd_idx == hidx_q) && (32'(rd_gen) == 32'(hgen_q))
                     && (htyp_q == etype_q);

  ghp_ram #(
    .WIDTH (IDX_W),
    .DEPTH (CAPACITY),
    .AW    (IDX_W)
  ) u_sparse_ram (
    .clk_i   (clk_i),
    .we_i    (sp_we),
    .addr_i  (sp_addr),
    .wdata_i (sp_wdata),
    .rdata_o (sp_rdata)
  );

  ghp_ram #(
    .WIDTH (DN_W),
    .DEPTH (CAPACITY),
    .AW    (IDX_W)
  ) u_dense_ram (
    .clk_i   (clk_i),
    .we_i    (dn_we),
    .addr_i  (dn_addr),
    .wdata_i (dn_wdata),
    .rdata_o (dn_rdata)
  );

  // Sequencer: read, check, write back
  always_comb begin
    state_d      = state_q;
    clr_busy_d   = clr_busy_q;
    clr_cnt_d    = clr_cnt_q;
    live_d       = live_q;
    etype_d      = cfg_we_i ? cfg_wdata_i : etype_q;
    out_valid_d  = out_valid_q;
    out_status_d = out_status_q;
    out_index_d  = out_index_q;
    out_gen_d    = out_gen_q;
    out_type_d   = out_type_q;
    out_pos_d    = out_pos_q;
    out_count_d  = out_count_q;
    cmd_d        = cmd_q;
    hidx_d       = hidx_q;
    hgen_d       = hgen_q;
    htyp_d       = htyp_q;
    pos_d        = pos_q;
    freed_d      = freed_q;
    res_status_d = res_status_q;
    res_idx_d    = res_idx_q;
    res_gen_d    = res_gen_q;
    sp_we        = 1'b0;
    sp_addr      = '0;
    sp_wdata     = '0;
    dn_we        = 1'b0;
    dn_addr      = '0;
    dn_wdata     = '0;

    // Drop the output item once taken
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    // Initialize both tables after reset
    if (clr_busy_q) begin
      sp_we     = 1'b1;
      sp_addr   = clr_cnt_q;
      sp_wdata  = clr_cnt_q;
      dn_we     = 1'b1;
      dn_addr   = clr_cnt_q;
      dn_wdata  = {clr_cnt_q, {GEN_BITS{1'b0}}};
      clr_cnt_d = clr_cnt_q + 1'b1;
      if (clr_cnt_q == IDX_W'(CAPACITY - 1)) begin
        clr_busy_d = 1'b0;
      end
    end

    case (state_q)
      S_IDLE: begin
        if (in_accept) begin
          cmd_d        = cmd_i;
          hidx_d       = IDX_W'(handle_index_i);
          hgen_d       = handle_generation_i;
          htyp_d       = handle_type_i;
          res_status_d = ST_OK;
          res_idx_d    = '0;
          res_gen_d    = '0;
          pos_d        = '0;
          case (cmd_i)
            CMD_ALLOC: begin
              if (live_q == CNT_W'(CAPACITY)) begin
                res_status_d = ST_FULL;
                state_d      = S_OUT;
              end else begin
                dn_addr = IDX_W'(live_q);
                pos_d   = IDX_W'(live_q);
                state_d = S_DATA;
              end
            end
            CMD_LOOKUP, CMD_FREE: begin
              if (32'(handle_index_i) >= 32'(CAPACITY)) begin
                res_status_d = ST_RANGE;
                state_d      = S_OUT;
              end else begin
                sp_addr = IDX_W'(handle_index_i);
                state_d = S_DENSE;
              end
            end
            default: begin
              if (32'(dense_position_i) >= 32'(live_q)) begin
                res_status_d = ST_NOT_LIVE;
                state_d      = S_OUT;
              end else begin
                dn_addr = IDX_W'(dense_position_i);
                pos_d   = IDX_W'(dense_position_i);
                state_d = S_DATA;
              end
            end
          endcase
        end
      end

      // Dense entry of an alloc or read is here
      S_DATA: begin
        res_idx_d = rd_idx;
        res_gen_d = rd_gen;
        if (cmd_q == CMD_ALLOC) begin
          live_d = live_q + 1'b1;
        end
        state_d = S_OUT;
      end

      // Sparse entry is here: check liveness, fetch dense entry
      S_DENSE: begin
        if (32'(sp_rdata) >= 32'(live_q)) begin
          res_status_d = ST_DEAD;
          state_d      = S_OUT;
        end else begin
          pos_d   = sp_rdata;
          dn_addr = sp_rdata;
          state_d = S_CHECK;
        end
      end

      // Compare the handle; start the free
      S_CHECK: begin
        if (!match) begin
          res_status_d = ST_STALE;
          pos_d        = '0;
          state_d      = S_OUT;
        end else begin
          res_idx_d = rd_idx;
          res_gen_d = rd_gen;
          state_d   = S_OUT;
          if (cmd_q == CMD_FREE) begin
            freed_d = {rd_idx, gen_inc};
            live_d  = live_m1;
            if (pos_q == last_pos) begin
              dn_we    = 1'b1;
              dn_addr  = pos_q;
              dn_wdata = {rd_idx, gen_inc};
            end else begin
              dn_addr = last_pos;
              state_d = S_MOVE;
            end
          end
        end
      end

      // Move the last live item into the freed position
      S_MOVE: begin
        dn_we    = 1'b1;
        dn_addr  = pos_q;
        dn_wdata = dn_rdata;
        sp_we    = 1'b1;
        sp_addr  = rd_idx;
        sp_wdata = pos_q;
        state_d  = S_SWAP;
      end

      // Park the freed handle at the old last position
      S_SWAP: begin
        dn_we    = 1'b1;
        dn_addr  = IDX_W'(live_q);
        dn_wdata = freed_q;
        sp_we    = 1'b1;
        sp_addr  = freed_q[DN_W-1:GEN_BITS];
        sp_wdata = IDX_W'(live_q);
        state_d  = S_OUT;
      end

      // Hand the result to the output register when it is free
      S_OUT: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d  = 1'b1;
          out_status_d = res_status_q;
          out_index_d  = HIdxW'(res_idx_q);
          out_gen_d    = HGenW'(res_gen_q);
          out_type_d   = (res_status_q == ST_OK) ? etype_q : '0;
          out_pos_d    = PosW'(pos_q);
          out_count_d  = CountW'(live_q);
          state_d      = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // State, counters and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      clr_busy_q   <= 1'b1;
      clr_cnt_q    <= '0;
      live_q       <= '0;
      etype_q      <= '0;
      out_valid_q  <= 1'b0;
      out_status_q <= ST_OK;
      out_index_q  <= '0;
      out_gen_q    <= '0;
      out_type_q   <= '0;
      out_pos_q    <= '0;
      out_count_q  <= '0;
    end else begin
      state_q      <= state_d;
      clr_busy_q   <= clr_busy_d;
      clr_cnt_q    <= clr_cnt_d;
      live_q       <= live_d;
      etype_q      <= etype_d;
      out_valid_q  <= out_valid_d;
      out_status_q <= out_status_d;
      out_index_q  <= out_index_d;
      out_gen_q    <= out_gen_d;
      out_type_q   <= out_type_d;
      out_pos_q    <= out_pos_d;
      out_count_q  <= out_count_d;
    end
  end

  // Hold the item at work
  always_ff @(posedge clk_i) begin
    cmd_q        <= cmd_d;
    hidx_q       <= hidx_d;
    hgen_q       <= hgen_d;
    htyp_q       <= htyp_d;
    pos_q        <= pos_d;
    freed_q      <= freed_d;
    res_status_q <= res_status_d;
    res_idx_q    <= res_idx_d;
    res_gen_q    <= res_gen_d;
  end

  assign out_valid_o      = out_valid_q;
  assign status_o         = out_status_q;
  assign out_index_o      = out_index_q;
  assign out_generation_o = out_gen_q;
  assign out_type_o       = out_type_q;
  assign out_position_o   = out_pos_q;
  assign live_count_o     = out_count_q;

endmodule

FILE: rtl/ghp_checker.sv
// ---------------------------------------------------------------------------
// ghp_checker
// Port-level checks of the handle pool, bound to the top level.
// ---------------------------------------------------------------------------
`include "generational_handle_pool_core_macros.svh"

module ghp_checker
  import ghp_pkg::*;
#(
  parameter int CAPACITY = DefCapacity
) (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               cfg_we_i,
  input logic [TypeW-1:0]   cfg_wdata_i,
  input logic               in_valid_i,
  input logic               in_ready_o,
  input logic [CmdW-1:0]    cmd_i,
  input logic [HIdxW-1:0]   handle_index_i,
  input logic [HGenW-1:0]   handle_generation_i,
  input logic [TypeW-1:0]   handle_type_i,
  input logic [PosW-1:0]    dense_position_i,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input logic [StatusW-1:0] status_o,
  input logic [HIdxW-1:0]   out_index_o,
  input logic [HGenW-1:0]   out_generation_o,
  input logic [TypeW-1:0]   out_type_o,
  input logic [PosW-1:0]    out_position_o,
  input logic [CountW-1:0]  live_count_o
);

  logic out_stall;
  logic in_take;
  logic out_failed;
  logic out_empty;
  logic out_full;

  assign out_stall  = out_valid_o && !out_ready_i;
  assign in_take    = in_valid_i && in_ready_o;
  assign out_failed = out_valid_o && (status_o != ST_OK);
  assign out_empty  = (out_index_o == '0) && (out_generation_o == '0)
                      && (out_type_o == '0) && (out_position_o == '0);
  assign out_full   = out_valid_o && (status_o == ST_FULL);

  // Hold a result until it is taken
  `GHP_ASSERT_NEXT(a_out_hold, out_stall, out_valid_o, "output item dropped while stalled")

  // One item at a time: no second accept right after one
  `GHP_ASSERT_NEXT(a_one_in_flight, in_take, !in_ready_o, "input taken while busy")

  // Failed commands carry an empty handle
  `GHP_ASSERT_IMPL(a_fail_zero, out_failed, out_empty, "failed item carries handle data")

  // Pool full is reported only at capacity
  `GHP_ASSERT_IMPL(a_full_count, out_full, live_count_o == CountW'(CAPACITY), "early pool full")

endmodule

bind generational_handle_pool_core ghp_checker #(
  .CAPACITY (CAPACITY)
) u_ghp_checker (
  .clk_i               (clk_i),
  .rst_ni              (rst_ni),
  .cfg_we_i            (cfg_we_i),
  .cfg_wdata_i         (cfg_wdata_i),
  .in_valid_i          (in_valid_i),
  .in_ready_o          (in_ready_o),
  .cmd_i               (cmd_i),
  .handle_index_i      (handle_index_i),
  .handle_generation_i (handle_generation_i),
  .handle_type_i       (handle_type_i),
  .dense_position_i    (dense_position_i),
  .out_valid_o         (out_valid_o),
  .out_ready_i         (out_ready_i),
  .status_o            (status_o),
  .out_index_o         (out_index_o),
  .out_generation_o    (out_generation_o),
  .out_type_o          (out_type_o),
  .out_position_o      (out_position_o),
  .live_count_o        (live_count_o)
);
